// ===== sv/assert_macros.svh =====
// assertion macros shared by the escape-time block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/mjet_pkg.sv =====
// shared types and constants of the escape-time fractal block
package mjet_pkg;

   localparam int unsigned FRAC_BITS = 28;
   localparam int unsigned ITER_W    = 8;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_MANDEL = 2'd1;
   localparam logic [1:0] KIND_JULIA  = 2'd2;

   localparam logic [2:0] REG_KIND     = 3'd0;
   localparam logic [2:0] REG_GAIN     = 3'd1;
   localparam logic [2:0] REG_JULIA_RE = 3'd2;
   localparam logic [2:0] REG_JULIA_IM = 3'd3;
   localparam logic [2:0] REG_OFFSET_X = 3'd4;
   localparam logic [2:0] REG_OFFSET_Y = 3'd5;
   localparam logic [2:0] REG_STEP_X   = 3'd6;
   localparam logic [2:0] REG_STEP_Y   = 3'd7;

   // |z|^2 limit of 4 in Q8.56
   localparam logic [63:0] ESCAPE_Q56 = 64'h0400_0000_0000_0000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] gain;
      logic [31:0] julia_re;
      logic [31:0] julia_im;
      logic [31:0] offset_x;
      logic [31:0] offset_y;
      logic [30:0] step_x;
      logic [30:0] step_y;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic map_mul;
      logic map_add;
      logic square;
      logic step;
      logic first;
      logic color;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic mode_ok;
      logic escaped;
      logic at_limit;
   } status_type;

endpackage

// ===== sv/mjet_csr.sv =====
// configuration register file
module mjet_csr
   import mjet_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_KIND:     cfg_in.kind     = csr_wdata[1:0];
            REG_GAIN:     cfg_in.gain     = csr_wdata[23:0];
            REG_JULIA_RE: cfg_in.julia_re = csr_wdata;
            REG_JULIA_IM: cfg_in.julia_im = csr_wdata;
            REG_OFFSET_X: cfg_in.offset_x = csr_wdata;
            REG_OFFSET_Y: cfg_in.offset_y = csr_wdata;
            REG_STEP_X:   cfg_in.step_x   = csr_wdata[30:0];
            REG_STEP_Y:   cfg_in.step_y   = csr_wdata[30:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind     <= KIND_MANDEL;
         cfg_ff.gain     <= 24'd1;
         cfg_ff.julia_re <= '0;
         cfg_ff.julia_im <= '0;
         cfg_ff.offset_x <= '0;
         cfg_ff.offset_y <= '0;
         cfg_ff.step_x   <= 31'd1048576;
         cfg_ff.step_y   <= 31'd1048576;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/mjet_ctrl.sv =====
// controller state machine sequencing mapping, iteration and output
`include "assert_macros.svh"
module mjet_ctrl
   import mjet_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_MUL,
      ST_MAP_ADD,
      ST_SQUARE,
      ST_STEP,
      ST_COLOR,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      first_ff, first_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.first    = first_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MAP_MUL;
            end
         end
         ST_MAP_MUL: begin
            cmd.map_mul = 1'b1;
            first_in    = status.mode_ok;
            state_in    = status.mode_ok ? ST_MAP_ADD : ST_COLOR;
         end
         ST_MAP_ADD: begin
            cmd.map_add = 1'b1;
            state_in    = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            first_in = 1'b0;
            priority if (first_ff) begin
               state_in = ST_SQUARE;
            end else if (status.escaped || status.at_limit) begin
               state_in = ST_COLOR;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_COLOR: begin
            cmd.color = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a waiting word is never overwritten
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.out_load && rsp_valid_ff, rsp_ready)
   // busy right after taking a pixel
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // the seed pass happens only after mapping
   `ASSERT_IMPLIES(a_first_in_loop, clock, reset, first_ff,
                   state_ff == ST_MAP_ADD || state_ff == ST_SQUARE || state_ff == ST_STEP)

endmodule

// ===== sv/mjet_dp.sv =====
// datapath: pixel mapping, complex square iteration and colour
`include "assert_macros.svh"
module mjet_dp
   import mjet_pkg::*;
#(
   parameter int MAX_ITER   = 128,
   parameter int PIXEL_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [PIXEL_BITS-1:0] pixel_x,
   input  logic [PIXEL_BITS-1:0] pixel_y,
   output logic [31:0]           pixel_color,
   output logic [ITER_W-1:0]     iterations
);

   localparam int CW = $clog2(MAX_ITER + 1);
   localparam int PW = PIXEL_BITS + 31;
   localparam int SW = (PIXEL_BITS + 33 > 38) ? PIXEL_BITS + 33 : 38;

   function automatic logic [31:0] sat_q(input logic [SW-1:0] v);
      logic [31:0] r;
      r = v[31:0];
      if (!v[SW-1] && (|v[SW-2:31])) begin
         r = 32'h7FFF_FFFF;
      end else if (v[SW-1] && !(&v[SW-2:31])) begin
         r = 32'h8000_0000;
      end
      return r;
   endfunction

   logic [PIXEL_BITS-1:0] px_ff, py_ff;
   logic [PW-1:0]         prod_x_ff, prod_y_ff;
   logic [31:0]           zr_ff, zi_ff, kr_ff, ki_ff;
   logic [63:0]           p_rr_ff, p_ii_ff, p_ri_ff;
   logic [CW-1:0]         count_ff;
   logic [31:0]           gain_count_ff;
   logic [31:0]           color_ff;
   logic [ITER_W-1:0]     iter_ff;

   logic [SW-1:0] cr_sum, ci_sum, nr_sum, ni_sum;
   logic [63:0]   sq, mag;
   logic [31:0]   nr, ni, color_in;
   logic          mode_ok;

   assign cr_sum = {{(SW-PW){1'b0}}, prod_x_ff} + {{(SW-32){cfg.offset_x[31]}}, cfg.offset_x};
   assign ci_sum = {{(SW-PW){1'b0}}, prod_y_ff} + {{(SW-32){cfg.offset_y[31]}}, cfg.offset_y};

   assign sq     = p_rr_ff - p_ii_ff;
   assign nr_sum = {{(SW-36){sq[63]}}, sq[63:FRAC_BITS]}
                 + {{(SW-32){kr_ff[31]}}, kr_ff};
   assign ni_sum = {{(SW-37){p_ri_ff[63]}}, p_ri_ff[63:FRAC_BITS-1]}
                 + {{(SW-32){ki_ff[31]}}, ki_ff};
   assign nr     = sat_q(nr_sum);
   assign ni     = sat_q(ni_sum);
   assign mag    = p_rr_ff + p_ii_ff;

   assign mode_ok = (cfg.kind == KIND_MANDEL) || (cfg.kind == KIND_JULIA);

   always_comb begin
      unique case (cfg.kind)
         KIND_MANDEL: color_in = (gain_count_ff << 5) + (gain_count_ff << 4)
                               + (gain_count_ff << 1);
         KIND_JULIA:  color_in = (gain_count_ff << 2) + gain_count_ff;
         default:     color_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         if (cmd.map_mul) begin
            count_ff <= '0;
         end else if (cmd.step && !cmd.first && !status.escaped) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff <= pixel_x;
         py_ff <= pixel_y;
      end
      if (cmd.map_mul) begin
         prod_x_ff <= px_ff * cfg.step_x;
         prod_y_ff <= py_ff * cfg.step_y;
      end
      if (cmd.map_add) begin
         zr_ff <= sat_q(cr_sum);
         zi_ff <= sat_q(ci_sum);
         if (cfg.kind == KIND_MANDEL) begin
            kr_ff <= sat_q(cr_sum);
            ki_ff <= sat_q(ci_sum);
         end else begin
            kr_ff <= cfg.julia_re;
            ki_ff <= cfg.julia_im;
         end
      end
      if (cmd.square) begin
         p_rr_ff <= $signed(zr_ff) * $signed(zr_ff);
         p_ii_ff <= $signed(zi_ff) * $signed(zi_ff);
         p_ri_ff <= $signed(zr_ff) * $signed(zi_ff);
      end
      if (cmd.step) begin
         zr_ff <= nr;
         zi_ff <= ni;
      end
      if (cmd.color) begin
         gain_count_ff <= 32'(cfg.gain) * 32'(count_ff);
      end
      if (cmd.out_load) begin
         color_ff <= color_in;
         iter_ff  <= ITER_W'(count_ff);
      end
   end

   assign status.mode_ok  = mode_ok;
   assign status.escaped  = (mag > ESCAPE_Q56);
   assign status.at_limit = (count_ff == CW'(MAX_ITER - 1));

   assign pixel_color = color_ff;
   assign iterations  = iter_ff;

   // count stays within the iteration limit
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(MAX_ITER))
   // mapping always restarts the count
   `ASSERT_NEXT(a_count_restart, clock, reset, cmd.map_mul, count_ff == '0)

endmodule

// ===== sv/mandelbrot_julia_escape_time.sv =====
// One pixel (req_pixel_x, req_pixel_y) in, one word (colour, iteration count) out. The pixel
// is mapped to c = offset + pixel*step by a multiply state and an add state, then z = z^2 + k
// runs in a loop of a square state (three 32x32 products) and a step state (the saturated
// update and the |z|^2 > 4 test on the squares of the next pass); the colour is then formed
// in a colour state and loaded into the result register in an output state. A pixel that
// reaches the iteration limit takes the longest; with kind none or the unused kind code the
// loop is skipped. One pixel is worked on at a time; the result register lets the next pixel
// be taken while a finished word waits. Write the configuration registers only while the
// block is idle.
module mandelbrot_julia_escape_time
   import mjet_pkg::*;
#(
   parameter int MAX_ITER   = 128,
   parameter int PIXEL_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_BITS-1:0] req_pixel_x,
   input  logic [PIXEL_BITS-1:0] req_pixel_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_pixel_color,
   output logic [ITER_W-1:0]     rsp_iterations
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   mjet_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   mjet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mjet_dp #(
      .MAX_ITER   (MAX_ITER),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .pixel_color (rsp_pixel_color),
      .iterations  (rsp_iterations)
   );

endmodule

// ===== verif/mandelbrot_julia_escape_time_tb.sv =====
// self-checking bench for the escape-time fractal block: directed table, then random frames
`timescale 1ns / 100ps

module mandelbrot_julia_escape_time_tb;
   import mjet_pkg::*;

   localparam int MAX_ITER       = 128;
   localparam int PIXEL_BITS     = 10;
   localparam int RANDOM_PIXELS  = 1432;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PLAN_ROWS      = 33;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_type;

   typedef struct packed {
      logic [31:0] color;
      logic [7:0]  iter;
   } pixel_word_type;

   typedef struct packed {
      row_kind_type   op;
      logic [2:0]     idx;
      logic [31:0]    data;
      logic [9:0]     px;
      logic [9:0]     py;
      logic           typed;
      pixel_word_type word;
   } plan_row_type;

   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_PIXEL, '0,           '0,             10'd0,    10'd0,    1'b1, '{32'd6400, 8'd128}},
      '{ROW_PIXEL, '0,           '0,             10'd1023, 10'd1023, 1'b1, '{32'd0, 8'd0}},
      '{ROW_PIXEL, '0,           '0,             10'd1023, 10'd0,    1'b1, '{32'd0, 8'd0}},
      '{ROW_PIXEL, '0,           '0,             10'd0,    10'd1023, 1'b1, '{32'd0, 8'd0}},
      '{ROW_PIXEL, '0,           '0,             10'd100,  10'd50,   1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd512,  10'd700,  1'b0, '0},
      // c = -2: |z|^2 lands exactly on 4 and keeps going
      '{ROW_WRITE, REG_OFFSET_X, 32'hE000_0000, 10'd0,    10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd0,    10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd1,    10'd0,    1'b0, '0},
      // mapped coordinate saturates high
      '{ROW_WRITE, REG_OFFSET_X, 32'h7FFF_FFFF, 10'd0,    10'd0,    1'b0, '0},
      '{ROW_WRITE, REG_STEP_X,   32'hFFFF_FFFF, 10'd0,    10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd1023, 10'd0,    1'b1, '{32'd0, 8'd0}},
      '{ROW_WRITE, REG_OFFSET_X, 32'h8000_0000, 10'd0,    10'd0,    1'b0, '0},
      '{ROW_WRITE, REG_STEP_X,   32'h0,         10'd0,    10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd700,  10'd0,    1'b1, '{32'd0, 8'd0}},
      '{ROW_WRITE, REG_OFFSET_X, 32'h0,         10'd0,    10'd0,    1'b0, '0},
      '{ROW_WRITE, REG_STEP_X,   32'h0010_0000, 10'd0,    10'd0,    1'b0, '0},
      '{ROW_WRITE, REG_GAIN,     32'hFFFF_FFFF, 10'd0,    10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd0,    10'd0,    1'b1,
        '{32'hFFFF_E700, 8'd128}},
      '{ROW_WRITE, REG_KIND,     32'(KIND_JULIA), 10'd0,   10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd0,    10'd0,    1'b1,
        '{32'h7FFF_FD80, 8'd128}},
      '{ROW_WRITE, REG_JULIA_RE, 32'hF333_3334, 10'd0,    10'd0,    1'b0, '0},
      '{ROW_WRITE, REG_JULIA_IM, 32'h027E_F9DB, 10'd0,    10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd300,  10'd200,  1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd0,    10'd1023, 1'b0, '0},
      '{ROW_WRITE, REG_KIND,     32'(KIND_NONE), 10'd0,    10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd0,    10'd0,    1'b1, '{32'd0, 8'd0}},
      '{ROW_PIXEL, '0,           '0,             10'd1023, 10'd1023, 1'b1, '{32'd0, 8'd0}},
      '{ROW_WRITE, REG_KIND,     32'(KIND_UNUSED), 10'd0,  10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd5,    10'd5,    1'b1, '{32'd0, 8'd0}},
      '{ROW_WRITE, REG_GAIN,     32'h0,         10'd0,    10'd0,    1'b0, '0},
      '{ROW_WRITE, REG_KIND,     32'(KIND_MANDEL), 10'd0,  10'd0,    1'b0, '0},
      '{ROW_PIXEL, '0,           '0,             10'd0,    10'd0,    1'b1, '{32'd0, 8'd128}}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [2:0]            csr_index = '0;
   logic [31:0]           csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIXEL_BITS-1:0] req_pixel_x = '0;
   logic [PIXEL_BITS-1:0] req_pixel_y = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [31:0]           rsp_pixel_color;
   logic [ITER_W-1:0]     rsp_iterations;

   cfg_type        frame_cfg;
   pixel_word_type expected_words [$];
   pixel_word_type oldest;
   int unsigned    mismatches = 0;
   bit             steady = 1'b0;

   mandelbrot_julia_escape_time #(
      .MAX_ITER   (MAX_ITER),
      .PIXEL_BITS (PIXEL_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_iterations  (rsp_iterations)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_q(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic pixel_word_type escape_time(logic [PIXEL_BITS-1:0] px,
                                                  logic [PIXEL_BITS-1:0] py);
      longint         cr, ci, kr, ki, zr, zi, nr, ni;
      logic [63:0]    mag, product;
      int unsigned    count, factor;
      pixel_word_type w;
      w = '0;
      if (frame_cfg.kind != KIND_MANDEL && frame_cfg.kind != KIND_JULIA) return w;
      cr = clamp_q(longint'($signed(frame_cfg.offset_x))
                   + longint'(px) * longint'(frame_cfg.step_x));
      ci = clamp_q(longint'($signed(frame_cfg.offset_y))
                   + longint'(py) * longint'(frame_cfg.step_y));
      if (frame_cfg.kind == KIND_MANDEL) begin
         kr = cr;
         ki = ci;
         factor = 50;
      end else begin
         kr = longint'($signed(frame_cfg.julia_re));
         ki = longint'($signed(frame_cfg.julia_im));
         factor = 5;
      end
      zr = cr;
      zi = ci;
      count = 0;
      while (count < MAX_ITER) begin
         nr = clamp_q(((zr * zr - zi * zi) >>> FRAC_BITS) + kr);
         ni = clamp_q(((zr * zi) >>> (FRAC_BITS - 1)) + ki);
         mag = nr * nr + ni * ni;
         if (mag > ESCAPE_Q56) break;
         zr = nr;
         zi = ni;
         count++;
      end
      product = 64'(frame_cfg.gain) * 64'(count) * 64'(factor);
      w.color = product[31:0];
      w.iter  = count[7:0];
      return w;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         REG_KIND:     frame_cfg.kind     = data[1:0];
         REG_GAIN:     frame_cfg.gain     = data[23:0];
         REG_JULIA_RE: frame_cfg.julia_re = data;
         REG_JULIA_IM: frame_cfg.julia_im = data;
         REG_OFFSET_X: frame_cfg.offset_x = data;
         REG_OFFSET_Y: frame_cfg.offset_y = data;
         REG_STEP_X:   frame_cfg.step_x   = data[30:0];
         REG_STEP_Y:   frame_cfg.step_y   = data[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   task automatic push_pixel(logic [PIXEL_BITS-1:0] px, logic [PIXEL_BITS-1:0] py,
                             logic typed, pixel_word_type given);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_words.push_back(typed ? given : escape_time(px, py));
   endtask

   task automatic program_frame();
      int unsigned flavor;
      logic [31:0] pick [4];
      logic [31:0] kind_w, gain_w, jre, jim, ox, oy, sx, sy;
      pick   = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      flavor = $urandom_range(0, 19);
      if (flavor == 0) begin
         kind_w = $urandom;
         gain_w = $urandom;
         jre    = $urandom;
         jim    = $urandom;
         ox     = $urandom;
         oy     = $urandom;
         sx     = $urandom;
         sy     = $urandom;
      end else if (flavor == 1) begin
         kind_w = $urandom;
         gain_w = pick[$urandom_range(0, 3)];
         jre    = pick[$urandom_range(0, 3)];
         jim    = pick[$urandom_range(0, 3)];
         ox     = pick[$urandom_range(0, 3)];
         oy     = pick[$urandom_range(0, 3)];
         sx     = pick[$urandom_range(0, 3)];
         sy     = pick[$urandom_range(0, 3)];
      end else begin
         // a frame over the interesting part of the plane
         if (flavor == 2) kind_w = 32'(KIND_NONE);
         else if (flavor == 3) kind_w = 32'(KIND_UNUSED);
         else if ($urandom_range(0, 1) != 0) kind_w = 32'(KIND_JULIA);
         else kind_w = 32'(KIND_MANDEL);
         gain_w = $urandom;
         jre    = 32'hF000_0000 + $urandom_range(0, 32'h1800_0000);
         jim    = 32'hF000_0000 + $urandom_range(0, 32'h2000_0000);
         ox     = 32'hD800_0000 + $urandom_range(0, 32'h3000_0000);
         oy     = 32'hE000_0000 + $urandom_range(0, 32'h2000_0000);
         sx     = $urandom_range(0, 32'h0010_0000) >> $urandom_range(0, 10);
         sy     = $urandom_range(0, 32'h0010_0000) >> $urandom_range(0, 10);
      end
      write_reg(REG_KIND, kind_w);
      write_reg(REG_GAIN, gain_w);
      write_reg(REG_JULIA_RE, jre);
      write_reg(REG_JULIA_IM, jim);
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_OFFSET_Y, oy);
      write_reg(REG_STEP_X, sx);
      write_reg(REG_STEP_Y, sy);
   endtask

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 7);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: word with nothing expected, color %h iterations %0d",
                     $time, rsp_pixel_color, rsp_iterations);
            mismatches++;
         end else begin
            oldest = expected_words.pop_front();
            if (rsp_pixel_color !== oldest.color) begin
               $display("%0t: pixel_color expected %h got %h",
                        $time, oldest.color, rsp_pixel_color);
               mismatches++;
            end
            if (rsp_iterations !== oldest.iter) begin
               $display("%0t: iterations expected %0d got %0d",
                        $time, oldest.iter, rsp_iterations);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
            quiet = 0;
         else
            quiet++;
         if (quiet == WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      int unsigned sent, burst;
      frame_cfg          = '0;
      frame_cfg.kind     = KIND_MANDEL;
      frame_cfg.gain     = 24'd1;
      frame_cfg.step_x   = 31'h0010_0000;
      frame_cfg.step_y   = 31'h0010_0000;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].op == ROW_WRITE) begin
            wait_idle();
            write_reg(PLAN[r].idx, PLAN[r].data);
         end else begin
            push_pixel(PLAN[r].px, PLAN[r].py, PLAN[r].typed, PLAN[r].word);
         end
      end

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         wait_idle();
         program_frame();
         burst = $urandom_range(20, 80);
         while (burst != 0 && sent < RANDOM_PIXELS) begin
            // a long stretch with both sides running flat out
            steady = (sent >= 500 && sent < 800);
            push_pixel(PIXEL_BITS'($urandom_range(0, 1023)),
                       PIXEL_BITS'($urandom_range(0, 1023)), 1'b0, '0);
            sent++;
            burst--;
         end
      end
      steady = 1'b0;

      wait_idle();
      repeat (2 * MAX_ITER + 16) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
